/* src/u8u16_pkg.sv */
package u8u16_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned RunW    = 3;
  localparam logic [RunW-1:0] RunOver = 3'd7;

  // Depth of the result queue and the room needed to take one more byte.
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned MaxRes  = 2;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             has_unit;
    logic             is_last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  // Value of the pending character: lead byte masked by the actual run length,
  // placed above the continuation payloads, truncated to 16 bits.
  function automatic logic [UnitW-1:0] char_value(
    input logic [ByteW-1:0] lead,
    input logic [RunW-1:0]  run,
    input logic [UnitW-1:0] acc
  );
    logic [UnitW-1:0] v;
    begin
      case (run)
        3'd1:    v = {8'h00, lead};
        3'd2:    v = {5'b0, lead[4:0], 6'b0} | acc;
        3'd3:    v = {lead[3:0], 12'b0} | acc;
        3'd4,
        3'd5,
        3'd6:    v = acc;
        3'd7:    v = 16'hFFFF;
        default: v = '0;
      endcase
      char_value = v;
    end
  endfunction

endpackage

/* src/u8u16_core.sv */
module u8u16_core
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             stream_end_i,
  output res_pair_t        res_o
);

  logic             pend_q, pend_d;
  logic [ByteW-1:0] lead_q, lead_d;
  logic [RunW-1:0]  run_q, run_d;
  logic [UnitW-1:0] acc_q, acc_d;

  logic             is_ascii, is_lead;
  logic             fl_old, fl_new, emit_empty;
  logic [UnitW-1:0] cv_old, cv_new;
  res_t             r_old, r_ascii, r_new, r_empty;

  always_comb begin
    is_ascii = ~in_byte_i[7];
    is_lead  = (in_byte_i[7:6] == 2'b11);

    // State after this byte, before the end-of-stream flush.
    pend_d = pend_q;
    lead_d = lead_q;
    run_d  = run_q;
    acc_d  = acc_q;
    if (is_ascii) begin
      pend_d = 1'b0;
      lead_d = '0;
      run_d  = '0;
      acc_d  = '0;
    end else if (is_lead) begin
      pend_d = 1'b1;
      lead_d = in_byte_i;
      run_d  = 3'd1;
      acc_d  = '0;
    end else if (pend_q) begin
      acc_d = {acc_q[UnitW-7:0], in_byte_i[5:0]};
      if (run_q != RunOver) begin
        run_d = run_q + 3'd1;
      end
    end

    cv_old     = char_value(lead_q, run_q, acc_q);
    cv_new     = char_value(lead_d, run_d, acc_d);
    fl_old     = pend_q & (is_ascii | is_lead);
    fl_new     = stream_end_i & pend_d;
    emit_empty = stream_end_i & ~fl_old & ~is_ascii & ~fl_new;

    r_old   = '{code_unit: cv_old, has_unit: 1'b1, is_last: 1'b0};
    r_ascii = '{code_unit: {8'h00, in_byte_i}, has_unit: 1'b1, is_last: stream_end_i};
    r_new   = '{code_unit: cv_new, has_unit: 1'b1, is_last: 1'b1};
    r_empty = '{code_unit: '0, has_unit: 1'b0, is_last: 1'b1};

    // Order the results: pending flush, ascii pass, final flush, empty marker.
    res_o = '{cnt: 2'd0, r0: r_empty, r1: r_empty};
    if (fl_old) begin
      res_o.cnt = 2'd1;
      res_o.r0  = r_old;
      if (is_ascii) begin
        res_o.cnt = 2'd2;
        res_o.r1  = r_ascii;
      end else if (fl_new) begin
        res_o.cnt = 2'd2;
        res_o.r1  = r_new;
      end else if (stream_end_i) begin
        res_o.r0.is_last = 1'b1;
      end
    end else if (is_ascii) begin
      res_o.cnt = 2'd1;
      res_o.r0  = r_ascii;
    end else if (fl_new) begin
      res_o.cnt = 2'd1;
      res_o.r0  = r_new;
    end else if (emit_empty) begin
      res_o.cnt = 2'd1;
      res_o.r0  = r_empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      lead_q <= '0;
      run_q  <= '0;
      acc_q  <= '0;
    end else if (accept_i) begin
      if (stream_end_i) begin
        pend_q <= 1'b0;
        lead_q <= '0;
        run_q  <= '0;
        acc_q  <= '0;
      end else begin
        pend_q <= pend_d;
        lead_q <= lead_d;
        run_q  <= run_d;
        acc_q  <= acc_d;
      end
    end
  end

endmodule

/* src/utf8_to_utf16_stream_decoder.sv */
// UTF-8 to UTF-16 stream decoder. Takes one UTF-8 byte per item on the slave
// side (tlast marks the final byte of a stream) and gives 16-bit code units on
// the master side. ASCII bytes pass through; a lead byte starts a character
// that continuation bytes extend, and the character is emitted when the next
// ASCII or lead byte arrives or the stream ends. Runs over six bytes give
// 0xFFFF, values are truncated to 16 bits, stray continuation bytes are
// dropped, and a final byte that yields no unit gives an empty item with
// tuser low and tlast high. Each accepted byte is decoded combinationally into
// at most two result items, which go into a four-entry result queue; a byte is
// taken in every cycle while the queue has room for two results, so the input
// runs at one byte per cycle while there is room and the output at one item per
// cycle while the master is ready; results are registered into the queue.
module utf8_to_utf16_stream_decoder
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave side
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] in_byte
  input  logic             s_axis_tlast_i,   // stream_end
  // master side
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [15:0] code_unit
  output logic             m_axis_tuser_o,   // [0] has_unit
  output logic             m_axis_tlast_o    // is_last
);

  logic             accept, pop;
  res_pair_t        res;

  res_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic [QPtrW-1:0] wr_ptr_p1;
  logic [QCntW-1:0] push_n;

  // Take a byte only when the queue can hold the worst case of two results.
  assign s_axis_tready_o = (cnt_q <= QCntW'(QDepth - MaxRes));
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  u8u16_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (s_axis_tdata_i),
    .stream_end_i (s_axis_tlast_i),
    .res_o        (res)
  );

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  assign m_axis_tdata_o  = q_mem[rd_ptr_q].code_unit;
  assign m_axis_tuser_o  = q_mem[rd_ptr_q].has_unit;
  assign m_axis_tlast_o  = q_mem[rd_ptr_q].is_last;

  assign wr_ptr_p1 = wr_ptr_q + QPtrW'(1);
  assign push_n    = accept ? QCntW'(res.cnt) : '0;

  // Queue storage: write the first result at the tail and the second after it.
  always_ff @(posedge clk_i) begin
    if (accept && res.cnt != 2'd0) begin
      q_mem[wr_ptr_q] <= res.r0;
    end
    if (accept && res.cnt == 2'd2) begin
      q_mem[wr_ptr_p1] <= res.r1;
    end
  end

  // Advance pointers and the fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + push_n - QCntW'(pop);
    end
  end

endmodule
